// File: design/joint_ramp_interpolator_unit_defines.svh
// Assertion macros for the checker file.
`ifndef JOINT_RAMP_INTERPOLATOR_UNIT_DEFINES_SVH
`define JOINT_RAMP_INTERPOLATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define JRI_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define JRI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/jri_pkg.sv
`default_nettype none
package jri_pkg;
   localparam int JOINT_COUNT = 12;
   localparam int IDX_W       = $clog2(JOINT_COUNT);
   localparam int JOINT_W     = 4;
   localparam int POS_W       = 16;
   localparam int STEPS_W     = 12;
   localparam int ACC_W       = 32;
   localparam int Q_SHIFT     = 12;
   localparam int SUM_W       = ACC_W + 1;
   localparam int DIVIDEND_W  = 30;
   localparam int MAG_W       = 29;
   localparam int DCNT_W      = $clog2(MAG_W + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W   = 3;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_SEED  = 2'd1,
      OP_START = 2'd2,
      OP_TICK  = 2'd3
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_WING_LOW      = 3'd0,
      REG_WING_HIGH     = 3'd1,
      REG_SHOULDER_LOW  = 3'd2,
      REG_SHOULDER_HIGH = 3'd3,
      REG_ELBOW_LOW     = 3'd4,
      REG_ELBOW_HIGH    = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      KIND_WING     = 2'd0,
      KIND_SHOULDER = 2'd1,
      KIND_ELBOW    = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE     = 4'b0001,
      ST_DIV_LOAD = 4'b0010,
      ST_DIV_WAIT = 4'b0100,
      ST_TICK     = 4'b1000
   } state_type;

   typedef struct packed {
      op_type                    op;
      logic [JOINT_W-1:0]        joint;
      logic signed [POS_W-1:0]   position;
      logic [STEPS_W-1:0]        steps;
   } cmd_type;

   typedef struct packed {
      logic signed [POS_W-1:0] wing_low;
      logic signed [POS_W-1:0] wing_high;
      logic signed [POS_W-1:0] shoulder_low;
      logic signed [POS_W-1:0] shoulder_high;
      logic signed [POS_W-1:0] elbow_low;
      logic signed [POS_W-1:0] elbow_high;
   } limits_type;

   localparam logic signed [POS_W-1:0] WING_LOW_RST      = -16'sd2048;
   localparam logic signed [POS_W-1:0] WING_HIGH_RST     = 16'sd2048;
   localparam logic signed [POS_W-1:0] SHOULDER_LOW_RST  = 16'sd0;
   localparam logic signed [POS_W-1:0] SHOULDER_HIGH_RST = 16'sd12861;
   localparam logic signed [POS_W-1:0] ELBOW_LOW_RST     = 16'sd1065;
   localparam logic signed [POS_W-1:0] ELBOW_HIGH_RST    = 16'sd7864;
endpackage
`default_nettype wire

// File: design/jri_front.sv
`default_nettype none
module jri_front (
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [1:0]                      req_op,
   input  wire logic [jri_pkg::JOINT_W-1:0]     req_joint,
   input  wire logic signed [jri_pkg::POS_W-1:0] req_position,
   input  wire logic [jri_pkg::STEPS_W-1:0]     req_steps,
   input  wire logic                            queue_full,
   output logic                                 push,
   output jri_pkg::cmd_type                     cmd
);
   logic keep;

   always_comb begin
      cmd.op       = jri_pkg::op_type'(req_op);
      cmd.joint    = req_joint;
      cmd.position = req_position;
      cmd.steps    = req_steps;
      case (cmd.op)
         jri_pkg::OP_LOAD, jri_pkg::OP_SEED: begin
            keep = (32'(req_joint) < jri_pkg::JOINT_COUNT);
         end
         jri_pkg::OP_START: begin
            keep = (req_steps != '0);
         end
         default: begin
            keep = 1'b1;
         end
      endcase
   end

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full && keep;
endmodule
`default_nettype wire

// File: design/jri_queue.sv
`default_nettype none
module jri_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire jri_pkg::cmd_type push_cmd,
   input  wire logic             pop,
   output jri_pkg::cmd_type      head_cmd,
   output logic                  empty,
   output logic                  full
);
   jri_pkg::cmd_type                  entry_ff [jri_pkg::QUEUE_DEPTH];
   logic [jri_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [jri_pkg::QPTR_W-1:0]        rd_ptr_ff, rd_ptr_in;
   logic [jri_pkg::QCNT_W-1:0]        count_ff, count_in;
   logic                              do_push, do_pop;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == jri_pkg::QCNT_W'(jri_pkg::QUEUE_DEPTH));
   assign head_cmd = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == jri_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == jri_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end
endmodule
`default_nettype wire

// File: design/jri_divider.sv
`default_nettype none
module jri_divider (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   input  wire logic signed [jri_pkg::DIVIDEND_W-1:0] dividend,
   input  wire logic [jri_pkg::STEPS_W-1:0]          divisor,
   output logic                                      done,
   output logic signed [jri_pkg::ACC_W-1:0]          quotient
);
   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic                              neg_ff, neg_in;
   logic [jri_pkg::DCNT_W-1:0]        cnt_ff, cnt_in;
   logic [jri_pkg::MAG_W-1:0]         mag_ff, mag_in;
   logic [jri_pkg::STEPS_W-1:0]       rem_ff, rem_in;
   logic [jri_pkg::STEPS_W:0]         trial;
   logic [jri_pkg::DIVIDEND_W-1:0]    abs_val;
   logic [jri_pkg::ACC_W-1:0]         q_ext;

   assign abs_val = dividend[jri_pkg::DIVIDEND_W-1] ? -dividend : dividend;
   assign trial   = {rem_ff, mag_ff[jri_pkg::MAG_W-1]};
   assign q_ext   = {{(jri_pkg::ACC_W - jri_pkg::MAG_W){1'b0}}, mag_ff};
   assign quotient = neg_ff ? -q_ext : q_ext;
   assign done    = done_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         neg_in  = dividend[jri_pkg::DIVIDEND_W-1];
         cnt_in  = jri_pkg::DCNT_W'(jri_pkg::MAG_W);
         mag_in  = abs_val[jri_pkg::MAG_W-1:0];
         rem_in  = '0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = jri_pkg::STEPS_W'(trial - {1'b0, divisor});
            mag_in = {mag_ff[jri_pkg::MAG_W-2:0], 1'b1};
         end else begin
            rem_in = trial[jri_pkg::STEPS_W-1:0];
            mag_in = {mag_ff[jri_pkg::MAG_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == jri_pkg::DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff <= neg_in;
      mag_ff <= mag_in;
      rem_ff <= rem_in;
   end
endmodule
`default_nettype wire

// File: design/jri_back.sv
`default_nettype none
module jri_back (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire jri_pkg::cmd_type                  head_cmd,
   input  wire logic                              queue_empty,
   output logic                                   pop,
   input  wire jri_pkg::limits_type               limits,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [jri_pkg::JOINT_W-1:0]            rsp_out_joint,
   output logic signed [jri_pkg::POS_W-1:0]       rsp_out_position,
   output logic                                   rsp_last,
   output logic                                   rsp_move_done
);
   localparam int N = jri_pkg::JOINT_COUNT;

   logic signed [jri_pkg::POS_W-1:0]  target_ff [N];
   logic signed [jri_pkg::ACC_W-1:0]  acc_ff    [N];
   logic signed [jri_pkg::ACC_W-1:0]  inc_ff    [N];

   jri_pkg::state_type                state_ff, state_in;
   logic [jri_pkg::IDX_W-1:0]         idx_ff, idx_in;
   jri_pkg::kind_type                 kind_ff, kind_in;
   logic [jri_pkg::STEPS_W-1:0]       rem_ff, rem_in;
   logic [jri_pkg::STEPS_W-1:0]       div_steps_ff, div_steps_in;
   logic                              moving_ff, moving_in;
   logic                              done_ff, done_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [jri_pkg::JOINT_W-1:0]       rsp_joint_ff;
   logic signed [jri_pkg::POS_W-1:0]  rsp_pos_ff;
   logic                              rsp_last_ff, rsp_done_ff;

   logic                              is_last, emit, div_start, div_done;
   logic                              wr_target, wr_seed, wr_inc;
   logic [jri_pkg::IDX_W-1:0]         cmd_idx;
   logic [jri_pkg::STEPS_W-1:0]       rem_dec;
   logic signed [jri_pkg::ACC_W-1:0]  acc_cur, inc_cur, quotient, acc_new, seed_val;
   logic signed [jri_pkg::SUM_W-1:0]  sum, lo_acc, hi_acc, clamped;
   logic signed [jri_pkg::POS_W-1:0]  lo, hi, tgt_cur;
   logic signed [jri_pkg::DIVIDEND_W-1:0] diff;

   assign cmd_idx  = jri_pkg::IDX_W'(head_cmd.joint);
   assign is_last  = (idx_ff == jri_pkg::IDX_W'(N - 1));
   assign acc_cur  = acc_ff[idx_ff];
   assign inc_cur  = inc_ff[idx_ff];
   assign tgt_cur  = target_ff[idx_ff];
   assign rem_dec  = rem_ff - 1'b1;
   assign seed_val = {{(jri_pkg::ACC_W - jri_pkg::POS_W - jri_pkg::Q_SHIFT)
                       {head_cmd.position[jri_pkg::POS_W-1]}},
                      head_cmd.position, {jri_pkg::Q_SHIFT{1'b0}}};
   assign diff = {{(jri_pkg::DIVIDEND_W - jri_pkg::POS_W - jri_pkg::Q_SHIFT)
                   {tgt_cur[jri_pkg::POS_W-1]}}, tgt_cur, {jri_pkg::Q_SHIFT{1'b0}}}
               - acc_cur[jri_pkg::DIVIDEND_W-1:0];

   always_comb begin
      case (kind_ff)
         jri_pkg::KIND_WING: begin
            lo = limits.wing_low;
            hi = limits.wing_high;
         end
         jri_pkg::KIND_SHOULDER: begin
            lo = limits.shoulder_low;
            hi = limits.shoulder_high;
         end
         default: begin
            lo = limits.elbow_low;
            hi = limits.elbow_high;
         end
      endcase
   end

   assign lo_acc = {{(jri_pkg::SUM_W - jri_pkg::POS_W - jri_pkg::Q_SHIFT)
                     {lo[jri_pkg::POS_W-1]}}, lo, {jri_pkg::Q_SHIFT{1'b0}}};
   assign hi_acc = {{(jri_pkg::SUM_W - jri_pkg::POS_W - jri_pkg::Q_SHIFT)
                     {hi[jri_pkg::POS_W-1]}}, hi, {jri_pkg::Q_SHIFT{1'b0}}};
   assign sum     = {acc_cur[jri_pkg::ACC_W-1], acc_cur} + {inc_cur[jri_pkg::ACC_W-1], inc_cur};
   assign clamped = (sum > hi_acc) ? hi_acc : ((sum < lo_acc) ? lo_acc : sum);
   assign acc_new = clamped[jri_pkg::ACC_W-1:0];

   jri_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff),
      .divisor  (div_steps_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      kind_in      = kind_ff;
      rem_in       = rem_ff;
      div_steps_in = div_steps_ff;
      moving_in    = moving_ff;
      done_in      = done_ff;
      pop          = 1'b0;
      wr_target    = 1'b0;
      wr_seed      = 1'b0;
      wr_inc       = 1'b0;
      div_start    = 1'b0;
      emit         = 1'b0;
      case (state_ff)
         jri_pkg::ST_IDLE: begin
            if (!queue_empty) begin
               pop = 1'b1;
               case (head_cmd.op)
                  jri_pkg::OP_LOAD: begin
                     wr_target = 1'b1;
                  end
                  jri_pkg::OP_SEED: begin
                     wr_seed = 1'b1;
                  end
                  jri_pkg::OP_START: begin
                     div_steps_in = head_cmd.steps;
                     idx_in       = '0;
                     state_in     = jri_pkg::ST_DIV_LOAD;
                  end
                  default: begin
                     if (moving_ff) begin
                        rem_in    = rem_dec;
                        done_in   = (rem_dec == '0);
                        moving_in = (rem_dec != '0);
                        idx_in    = '0;
                        kind_in   = jri_pkg::KIND_WING;
                        state_in  = jri_pkg::ST_TICK;
                     end
                  end
               endcase
            end
         end
         jri_pkg::ST_DIV_LOAD: begin
            div_start = 1'b1;
            state_in  = jri_pkg::ST_DIV_WAIT;
         end
         jri_pkg::ST_DIV_WAIT: begin
            if (div_done) begin
               wr_inc = 1'b1;
               if (is_last) begin
                  rem_in    = div_steps_ff;
                  moving_in = 1'b1;
                  state_in  = jri_pkg::ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = jri_pkg::ST_DIV_LOAD;
               end
            end
         end
         jri_pkg::ST_TICK: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               emit = 1'b1;
               if (is_last) begin
                  state_in = jri_pkg::ST_IDLE;
               end else begin
                  idx_in  = idx_ff + 1'b1;
                  kind_in = (kind_ff == jri_pkg::KIND_ELBOW) ? jri_pkg::KIND_WING
                                                              : jri_pkg::kind_type'(kind_ff + 1'b1);
               end
            end
         end
         default: begin
            state_in = jri_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jri_pkg::ST_IDLE;
         idx_ff       <= '0;
         kind_ff      <= jri_pkg::KIND_WING;
         rem_ff       <= '0;
         div_steps_ff <= '0;
         moving_ff    <= 1'b0;
         done_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < N; i++) begin
            target_ff[i] <= '0;
            acc_ff[i]    <= '0;
            inc_ff[i]    <= '0;
         end
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         kind_ff      <= kind_in;
         rem_ff       <= rem_in;
         div_steps_ff <= div_steps_in;
         moving_ff    <= moving_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_target) begin
            target_ff[cmd_idx] <= head_cmd.position;
         end
         if (wr_seed) begin
            acc_ff[cmd_idx] <= seed_val;
         end
         if (emit) begin
            acc_ff[idx_ff] <= acc_new;
         end
         if (wr_inc) begin
            inc_ff[idx_ff] <= quotient;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_joint_ff <= jri_pkg::JOINT_W'(idx_ff);
         rsp_pos_ff   <= acc_new[jri_pkg::Q_SHIFT + jri_pkg::POS_W - 1:jri_pkg::Q_SHIFT];
         rsp_last_ff  <= is_last;
         rsp_done_ff  <= done_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_joint    = rsp_joint_ff;
   assign rsp_out_position = rsp_pos_ff;
   assign rsp_last         = rsp_last_ff;
   assign rsp_move_done    = rsp_done_ff;
endmodule
`default_nettype wire

// File: design/joint_ramp_interpolator_unit.sv
// Load and seed words are written by the back end as it pops them from the queue's registers.
// A start runs the serial divider (one quotient bit a cycle) once for each of the 12 joints.
// A tick gives one registered result word per joint, one word per cycle while not stalled.
// Throughput is bounded by the back end; the 2-word queue accepts words while it works.
// Reset is synchronous: it clears all joint state and returns the limits to defaults.
`default_nettype none
module joint_ramp_interpolator_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [1:0]                           req_op,
   input  wire logic [jri_pkg::JOINT_W-1:0]          req_joint,
   input  wire logic signed [jri_pkg::POS_W-1:0]     req_position,
   input  wire logic [jri_pkg::STEPS_W-1:0]          req_steps,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [jri_pkg::JOINT_W-1:0]               rsp_out_joint,
   output logic signed [jri_pkg::POS_W-1:0]          rsp_out_position,
   output logic                                      rsp_last,
   output logic                                      rsp_move_done,
   input  wire logic                                 csr_wen,
   input  wire logic [jri_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [jri_pkg::POS_W-1:0]            csr_wdata
);
   jri_pkg::limits_type limits_ff;
   jri_pkg::cmd_type    push_cmd, head_cmd;
   logic                push, pop, queue_empty, queue_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.wing_low      <= jri_pkg::WING_LOW_RST;
         limits_ff.wing_high     <= jri_pkg::WING_HIGH_RST;
         limits_ff.shoulder_low  <= jri_pkg::SHOULDER_LOW_RST;
         limits_ff.shoulder_high <= jri_pkg::SHOULDER_HIGH_RST;
         limits_ff.elbow_low     <= jri_pkg::ELBOW_LOW_RST;
         limits_ff.elbow_high    <= jri_pkg::ELBOW_HIGH_RST;
      end else if (csr_wen) begin
         case (csr_index)
            jri_pkg::REG_WING_LOW:      limits_ff.wing_low      <= csr_wdata;
            jri_pkg::REG_WING_HIGH:     limits_ff.wing_high     <= csr_wdata;
            jri_pkg::REG_SHOULDER_LOW:  limits_ff.shoulder_low  <= csr_wdata;
            jri_pkg::REG_SHOULDER_HIGH: limits_ff.shoulder_high <= csr_wdata;
            jri_pkg::REG_ELBOW_LOW:     limits_ff.elbow_low     <= csr_wdata;
            jri_pkg::REG_ELBOW_HIGH:    limits_ff.elbow_high    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   jri_front u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_joint    (req_joint),
      .req_position (req_position),
      .req_steps    (req_steps),
      .queue_full   (queue_full),
      .push         (push),
      .cmd          (push_cmd)
   );

   jri_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   jri_back u_back (
      .clock            (clock),
      .reset            (reset),
      .head_cmd         (head_cmd),
      .queue_empty      (queue_empty),
      .pop              (pop),
      .limits           (limits_ff),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_joint    (rsp_out_joint),
      .rsp_out_position (rsp_out_position),
      .rsp_last         (rsp_last),
      .rsp_move_done    (rsp_move_done)
   );
endmodule
`default_nettype wire

// File: design/jri_checker.sv
`default_nettype none
`include "joint_ramp_interpolator_unit_defines.svh"
module jri_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_stall,
   input wire logic [jri_pkg::JOINT_W-1:0]      rsp_out_joint,
   input wire logic [jri_pkg::POS_W-1:0]        rsp_out_position,
   input wire logic                             rsp_last,
   input wire logic                             rsp_move_done
);
   `JRI_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "result word dropped while stalled")
   `JRI_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_out_position) && $stable(rsp_out_joint) && $stable(rsp_last) && $stable(rsp_move_done), "stalled result word changed")
   `JRI_ASSERT_NOW(a_last_joint, rsp_valid && rsp_last, 32'(rsp_out_joint) == jri_pkg::JOINT_COUNT - 1, "last flag on wrong joint")
   `JRI_ASSERT_NOW(a_joint_range, rsp_valid, 32'(rsp_out_joint) < jri_pkg::JOINT_COUNT, "result joint out of range")
endmodule

bind joint_ramp_interpolator_unit jri_checker u_jri_checker (.*);
`default_nettype wire
